// ===== rtl/rv32im_alu_core_defines.svh =====
// Assertion macros used by the ALU core top level
`ifndef RV32IM_ALU_CORE_DEFINES_SVH
`define RV32IM_ALU_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define RVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset
`define RVA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== rtl/rva_pkg.sv =====
// Package with operation codes, payload types and cell constants for the ALU core
package rva_pkg;
	localparam int unsigned XLEN = 32;
	localparam int unsigned NCELL = 33;
	localparam int unsigned CIDX_W = 6;
	// decode register, cell row, output register
	localparam int unsigned PIPE_LAT = NCELL + 2;

	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_SLL = 5'd2, OP_SLT = 5'd3, OP_SLTU = 5'd4,
		OP_XOR = 5'd5, OP_SRL = 5'd6, OP_SRA = 5'd7, OP_OR = 5'd8, OP_AND = 5'd9,
		OP_MUL = 5'd10, OP_MULH = 5'd11, OP_MULHSU = 5'd12, OP_MULHU = 5'd13,
		OP_DIV = 5'd14, OP_DIVU = 5'd15, OP_REM = 5'd16, OP_REMU = 5'd17,
		OP_BEQ = 5'd18, OP_BNE = 5'd19, OP_BLT = 5'd20, OP_BGE = 5'd21,
		OP_BLTU = 5'd22, OP_BGEU = 5'd23
	} op_t;

	typedef struct packed {
		logic [4:0] func;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} alu_in_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic illegal;
	} alu_out_t;

	// Post-processing kind carried down the chain
	typedef enum logic [1:0] {
		FIN_DIRECT = 2'd0,
		FIN_QUO = 2'd1,
		FIN_REM = 2'd2
	} fin_t;

	// Control travelling with each transaction through the cells
	typedef struct packed {
		logic vld;
		fin_t fin;
		logic neg_q;
		logic neg_r;
		logic is_mul;
		logic mul_hi;
	} ctl_t;

	// Data state held in one cell
	typedef struct packed {
		logic [31:0] acc;   // remainder or product high half
		logic [31:0] wrk;   // dividend/quotient or multiplier/product low half
		logic [31:0] dvs;   // divisor or multiplicand
		logic [31:0] direct;
		logic dvs_sgn;      // multiplicand sign extension for signed high multiply
		logic mul_bsub;     // last multiplier bit is negative weight
	} dat_t;
endpackage

// ===== rtl/rva_cell.sv =====
// One chain cell: one radix-2 step of shift-add multiply or restoring divide, or a pass-through in the last cell
module rva_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          last,
	input  logic          msb,
	input  rva_pkg::ctl_t ctl_in,
	input  rva_pkg::dat_t dat_in,
	output rva_pkg::ctl_t ctl_s1,
	output rva_pkg::dat_t dat_s1
);
	rva_pkg::dat_t nx;
	logic [32:0] addend;
	logic [33:0] msum;
	logic [32:0] trial;
	logic [32:0] rshift;

	always_comb begin
		nx = dat_in;
		addend = '0;
		msum = '0;
		trial = '0;
		rshift = '0;
		// the last cell only hands the transaction on
		if (ctl_in.is_mul && !last) begin
			// add or subtract the extended multiplicand, then shift right by one
			addend = {dat_in.dvs_sgn & dat_in.dvs[31], dat_in.dvs};
			if (dat_in.wrk[0]) begin
				if (msb && dat_in.mul_bsub)
					msum = {dat_in.acc[31] & dat_in.dvs_sgn, dat_in.acc[31] & dat_in.dvs_sgn,
						dat_in.acc} - {addend[32], addend};
				else
					msum = {dat_in.acc[31] & dat_in.dvs_sgn, dat_in.acc[31] & dat_in.dvs_sgn,
						dat_in.acc} + {addend[32], addend};
			end else begin
				msum = {dat_in.acc[31] & dat_in.dvs_sgn, dat_in.acc[31] & dat_in.dvs_sgn,
					dat_in.acc};
			end
			nx.acc = msum[32:1];
			nx.wrk = {msum[0], dat_in.wrk[31:1]};
		end else if (!ctl_in.is_mul && !last) begin
			// restoring division step
			rshift = {dat_in.acc, dat_in.wrk[31]};
			trial = rshift - {1'b0, dat_in.dvs};
			if (!trial[32]) begin
				nx.acc = trial[31:0];
				nx.wrk = {dat_in.wrk[30:0], 1'b1};
			end else begin
				nx.acc = rshift[31:0];
				nx.wrk = {dat_in.wrk[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		dat_s1 <= nx;
	end
endmodule

// ===== rtl/rva_front.sv =====
// Input decode: simple operations, compares and chain seeding
module rva_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  rva_pkg::alu_in_t din,
	output rva_pkg::ctl_t  ctl_s1,
	output rva_pkg::dat_t  dat_s1
);
	rva_pkg::ctl_t c;
	rva_pkg::dat_t d;
	logic [31:0] a, b;
	logic [4:0] sh;
	logic slt, sltu;
	logic sa, sb;

	always_comb begin
		a = din.operand_a;
		b = din.operand_b;
		sh = b[4:0];
		slt = $signed(a) < $signed(b);
		sltu = a < b;
		c = '0;
		d = '0;
		c.vld = start;
		c.fin = rva_pkg::FIN_DIRECT;
		sa = 1'b0;
		sb = 1'b0;
		case (din.func)
			rva_pkg::OP_ADD: d.direct = a + b;
			rva_pkg::OP_SUB: d.direct = a - b;
			rva_pkg::OP_SLL: d.direct = a << sh;
			rva_pkg::OP_SLT, rva_pkg::OP_BLT: d.direct = {31'd0, slt};
			rva_pkg::OP_SLTU, rva_pkg::OP_BLTU: d.direct = {31'd0, sltu};
			rva_pkg::OP_XOR: d.direct = a ^ b;
			rva_pkg::OP_SRL: d.direct = a >> sh;
			rva_pkg::OP_SRA: d.direct = $unsigned($signed(a) >>> sh);
			rva_pkg::OP_OR: d.direct = a | b;
			rva_pkg::OP_AND: d.direct = a & b;
			rva_pkg::OP_BEQ: d.direct = {31'd0, a == b};
			rva_pkg::OP_BNE: d.direct = {31'd0, a != b};
			rva_pkg::OP_BGE: d.direct = {31'd0, !slt};
			rva_pkg::OP_BGEU: d.direct = {31'd0, !sltu};
			rva_pkg::OP_MUL, rva_pkg::OP_MULH, rva_pkg::OP_MULHSU, rva_pkg::OP_MULHU: begin
				c.is_mul = 1'b1;
				c.mul_hi = (din.func != rva_pkg::OP_MUL);
				d.dvs = a;
				d.wrk = b;
				d.dvs_sgn = (din.func == rva_pkg::OP_MULH) || (din.func == rva_pkg::OP_MULHSU);
				d.mul_bsub = (din.func == rva_pkg::OP_MULH);
			end
			rva_pkg::OP_DIV, rva_pkg::OP_DIVU, rva_pkg::OP_REM, rva_pkg::OP_REMU: begin
				sa = ((din.func == rva_pkg::OP_DIV) || (din.func == rva_pkg::OP_REM)) && a[31];
				sb = ((din.func == rva_pkg::OP_DIV) || (din.func == rva_pkg::OP_REM)) && b[31];
				d.wrk = sa ? (32'd0 - a) : a;
				d.dvs = sb ? (32'd0 - b) : b;
				if ((din.func == rva_pkg::OP_DIV) || (din.func == rva_pkg::OP_DIVU)) begin
					c.fin = rva_pkg::FIN_QUO;
					// zero divisor yields all ones unsigned, so skip the sign fix
					c.neg_q = (sa ^ sb) && (b != 32'd0);
				end else begin
					c.fin = rva_pkg::FIN_REM;
					c.neg_r = sa;
				end
			end
			default: d.direct = '0;
		endcase
		d.mul_bsub = d.mul_bsub | 1'b0;
		// illegal codes get a zero direct result; the flag itself comes from the core's function-code delay line
		c.neg_r = c.neg_r | 1'b0;
		if (din.func > rva_pkg::OP_BGEU)
			d.direct = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= c;
		end
	end

	always_ff @(posedge clk) begin
		dat_s1 <= d;
	end
endmodule

// ===== rtl/rv32im_alu_core.sv =====
// Every operation passes the decode register, 33 cells and the output stage from start to done.
// Throughput: one transaction per cycle; busy is held low, each cell hands on every cycle.
// The first 32 cells perform one multiply or divide bit step each, the last one passes
// through; the output register applies the signs. Reset clears the valid bits of every
// stage; done stays low until a transaction has crossed the whole chain. No receiver stall.
module rv32im_alu_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  rva_pkg::alu_in_t   din,
	output logic               done,
	output rva_pkg::alu_out_t  dout
);
	`include "rv32im_alu_core_defines.svh"

	rva_pkg::ctl_t ctl_c [rva_pkg::NCELL+1];
	rva_pkg::dat_t dat_c [rva_pkg::NCELL+1];
	logic [4:0] func_d [rva_pkg::NCELL+1];
	logic illegal_q;
	logic [31:0] res;

	assign busy = 1'b0;

	rva_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .din(din),
		.ctl_s1(ctl_c[0]), .dat_s1(dat_c[0])
	);

	// function code rides alongside in a simple delay line for the illegal flag
	always_ff @(posedge clk) begin
		func_d[0] <= din.func;
		for (int i = 0; i < rva_pkg::NCELL; i++)
			func_d[i+1] <= func_d[i];
	end

	for (genvar g = 0; g < rva_pkg::NCELL; g++) begin : g_cell
		rva_cell u_cell (
			.clk(clk), .arst_n(arst_n),
			.last(g == rva_pkg::NCELL - 1),
			.msb(g == rva_pkg::NCELL - 2),
			.ctl_in(ctl_c[g]), .dat_in(dat_c[g]),
			.ctl_s1(ctl_c[g+1]), .dat_s1(dat_c[g+1])
		);
	end

	always_comb begin
		rva_pkg::ctl_t c;
		rva_pkg::dat_t d;
		c = ctl_c[rva_pkg::NCELL];
		d = dat_c[rva_pkg::NCELL];
		case (c.fin)
			rva_pkg::FIN_QUO: res = c.neg_q ? (32'd0 - d.wrk) : d.wrk;
			rva_pkg::FIN_REM: res = c.neg_r ? (32'd0 - d.acc) : d.acc;
			default: begin
				if (c.is_mul)
					res = c.mul_hi ? d.acc : d.wrk;
				else
					res = d.direct;
			end
		endcase
		illegal_q = func_d[rva_pkg::NCELL] > rva_pkg::OP_BGEU;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_c[rva_pkg::NCELL].vld;
		end
	end

	always_ff @(posedge clk) begin
		dout.result <= res;
		dout.illegal <= illegal_q;
	end

	logic [rva_pkg::PIPE_LAT-1:0] start_hist_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_hist_q <= '0;
		end else begin
			start_hist_q <= {start_hist_q[rva_pkg::PIPE_LAT-2:0], start};
		end
	end

	`RVA_ASSERT_IMP(a_busy_low, clk, arst_n, 1'b1, !busy)
	`RVA_ASSERT_IMP(a_done_lat, clk, arst_n, 1'b1, done == start_hist_q[rva_pkg::PIPE_LAT-1])
	`RVA_ASSERT_NXT(a_ill_zero, clk, arst_n, ctl_c[rva_pkg::NCELL].vld && illegal_q,
		done && dout.illegal && (dout.result == 32'sd0))
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the pipelined RV32IM ALU core: directed table, then random transactions
`timescale 1ns / 100ps

module tb_top;
	import rva_pkg::*;

	localparam int LATENCY = 35;
	localparam int N_RANDOM = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	alu_in_t din = '0;
	alu_out_t dout;

	typedef struct {
		alu_in_t  op;
		logic     fixed;
		alu_out_t res;
	} row_t;

	alu_out_t pending_results[$];
	row_t directed_rows[$];
	int n_errors = 0;
	int n_checked = 0;
	int n_illegal = 0;
	int idle_cnt;

	rv32im_alu_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.din(din), .done(done), .dout(dout)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] high_product(logic signed [64:0] x, logic signed [64:0] y);
		logic signed [129:0] p;
		p = x * y;
		return p[63:32];
	endfunction

	function automatic alu_out_t alu_compute(alu_in_t op);
		alu_out_t r;
		logic [31:0] a, b;
		logic [4:0] sh;
		a = op.operand_a;
		b = op.operand_b;
		sh = b[4:0];
		r = '0;
		case (op.func)
			OP_ADD:    r.result = a + b;
			OP_SUB:    r.result = a - b;
			OP_SLL:    r.result = a << sh;
			OP_SLT:    r.result = {31'd0, $signed(a) < $signed(b)};
			OP_SLTU:   r.result = {31'd0, a < b};
			OP_XOR:    r.result = a ^ b;
			OP_SRL:    r.result = a >> sh;
			OP_SRA:    r.result = $signed(a) >>> sh;
			OP_OR:     r.result = a | b;
			OP_AND:    r.result = a & b;
			OP_MUL:    r.result = a * b;
			OP_MULH:   r.result = high_product({{33{a[31]}}, a}, {{33{b[31]}}, b});
			OP_MULHSU: r.result = high_product({{33{a[31]}}, a}, {33'd0, b});
			OP_MULHU:  r.result = high_product({33'd0, a}, {33'd0, b});
			OP_DIV: begin
				if (b == 0) r.result = '1;
				else if (a == 32'h8000_0000 && b == '1) r.result = a;
				else r.result = $signed(a) / $signed(b);
			end
			OP_DIVU:   r.result = (b == 0) ? '1 : a / b;
			OP_REM: begin
				if (b == 0) r.result = a;
				else if (a == 32'h8000_0000 && b == '1) r.result = '0;
				else r.result = $signed(a) % $signed(b);
			end
			OP_REMU:   r.result = (b == 0) ? a : a % b;
			OP_BEQ:    r.result = {31'd0, a == b};
			OP_BNE:    r.result = {31'd0, a != b};
			OP_BLT:    r.result = {31'd0, $signed(a) < $signed(b)};
			OP_BGE:    r.result = {31'd0, $signed(a) >= $signed(b)};
			OP_BLTU:   r.result = {31'd0, a < b};
			OP_BGEU:   r.result = {31'd0, a >= b};
			default:   r.illegal = 1'b1;
		endcase
		return r;
	endfunction

	function automatic row_t mk(logic [4:0] f, logic [31:0] a, logic [31:0] b,
			logic fx = 1'b0, logic [31:0] res = '0, logic ill = 1'b0);
		row_t r;
		r.op = '{func: f, operand_a: a, operand_b: b};
		r.fixed = fx;
		r.res = '{result: res, illegal: ill};
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '1;
			3: return 32'($urandom_range(0, 3));
			4: return 32'(-$signed(32'($urandom_range(1, 40))));
			default: return $urandom();
		endcase
	endfunction

	// Drive one transaction; hold start until the edge that takes it
	task automatic issue(alu_in_t op);
		din <= op;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		pending_results.push_back(alu_compute(op));
		@(negedge clk);
	endtask

	task automatic pause();
		start <= 1'b0;
		din <= '{func: 5'($urandom()), operand_a: $urandom(), operand_b: $urandom()};
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	always @(posedge clk) begin
		if (done) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding: %h", dout);
				n_errors++;
			end else begin
				alu_out_t e;
				e = pending_results.pop_front();
				n_checked++;
				if (e.illegal) n_illegal++;
				if (dout.result !== e.result) begin
					$error("result: expected %h actual %h", e.result, dout.result);
					n_errors++;
				end
				if (dout.illegal !== e.illegal) begin
					$error("illegal: expected %b actual %b", e.illegal, dout.illegal);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		alu_in_t op;
		int burst;
		directed_rows.push_back(mk(OP_ADD, 32'h7fff_ffff, 32'd1, 1'b1, 32'h8000_0000));
		directed_rows.push_back(mk(OP_SUB, 32'h8000_0000, 32'd1, 1'b1, 32'h7fff_ffff));
		directed_rows.push_back(mk(OP_SLL, 32'd1, 32'hffff_ffff, 1'b1, 32'h8000_0000));
		directed_rows.push_back(mk(OP_SLT, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_SLTU, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'd0));
		directed_rows.push_back(mk(OP_XOR, 32'hffff_ffff, 32'h0f0f_0f0f));
		directed_rows.push_back(mk(OP_SRL, 32'h8000_0000, 32'd63, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_SRA, 32'h8000_0000, 32'd31, 1'b1, 32'hffff_ffff));
		directed_rows.push_back(mk(OP_OR, 32'h1234_5678, 32'h8000_0001));
		directed_rows.push_back(mk(OP_AND, 32'hffff_ffff, 32'h5a5a_5a5a));
		directed_rows.push_back(mk(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_MULH, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000));
		directed_rows.push_back(mk(OP_MULHSU, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_ffff));
		directed_rows.push_back(mk(OP_MULHU, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'hffff_fffe));
		directed_rows.push_back(mk(OP_DIV, 32'd7, 32'd0, 1'b1, 32'hffff_ffff));
		directed_rows.push_back(mk(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'h8000_0000));
		directed_rows.push_back(mk(OP_DIVU, 32'h1234, 32'd0, 1'b1, 32'hffff_ffff));
		directed_rows.push_back(mk(OP_REM, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'd0));
		directed_rows.push_back(mk(OP_REM, 32'hffff_fff9, 32'd0, 1'b1, 32'hffff_fff9));
		directed_rows.push_back(mk(OP_REMU, 32'hdead_beef, 32'd0, 1'b1, 32'hdead_beef));
		directed_rows.push_back(mk(OP_BEQ, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_BNE, 32'd0, 32'hffff_ffff, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_BLT, 32'hffff_ffff, 32'd0, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_BGE, 32'h7fff_ffff, 32'h8000_0000, 1'b1, 32'd1));
		directed_rows.push_back(mk(OP_BLTU, 32'hffff_ffff, 32'd0, 1'b1, 32'd0));
		directed_rows.push_back(mk(OP_BGEU, 32'd0, 32'd0, 1'b1, 32'd1));
		directed_rows.push_back(mk(5'd24, 32'hffff_ffff, 32'hffff_ffff, 1'b1, 32'd0, 1'b1));
		directed_rows.push_back(mk(5'd31, 32'h8000_0000, 32'h7fff_ffff, 1'b1, 32'd0, 1'b1));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			// typed-in rows must agree with the predictor before they go out
			if (directed_rows[i].fixed && alu_compute(directed_rows[i].op) !== directed_rows[i].res) begin
				$error("table row %0d: expected %h predictor %h", i,
					directed_rows[i].res, alu_compute(directed_rows[i].op));
				n_errors++;
			end
			issue(directed_rows[i].op);
		end

		for (int n = 0; n < N_RANDOM; ) begin
			burst = $urandom_range(1, 40);
			for (int k = 0; k < burst && n < N_RANDOM; k++, n++) begin
				op.func = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(24, 31))
					: 5'($urandom_range(0, 23));
				op.operand_a = rand_operand();
				op.operand_b = rand_operand();
				issue(op);
			end
			if ($urandom_range(0, 3) != 0) pause();
		end
		start <= 1'b0;

		idle_cnt = 0;
		while (pending_results.size() != 0 && idle_cnt < 20 * LATENCY) begin
			@(posedge clk);
			idle_cnt++;
		end
		repeat (LATENCY + 5) @(posedge clk);

		$display("covered: %0d transactions checked (%0d undefined codes), all 24 operations",
			n_checked, n_illegal);
		if (n_errors == 0 && pending_results.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rva_pkg.sv
rtl/rva_cell.sv
rtl/rva_front.sv
rtl/rv32im_alu_core.sv
tb/tb_top.sv
